FILE: rtl/key_bitmap_change_events_macros.svh
// Assertion macros used by the key bitmap change event RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef KEY_BITMAP_CHANGE_EVENTS_MACROS_SVH
`define KEY_BITMAP_CHANGE_EVENTS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KBCE_ASSERT_NOW(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("kbce assertion failed");

// Next-cycle implication, checked outside reset.
`define KBCE_ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("kbce assertion failed");

`endif

FILE: rtl/kbce_pkg.sv
// Types and constants for the key bitmap change event block.
// No dependencies.
package kbce_pkg;

  localparam int BITMAP_W = 40;
  localparam int REASON_W = 8;
  localparam int KEY_ROW_W = 4;
  localparam int KEY_COL_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic ACTION_APPLY = 1'b0;
  localparam logic ACTION_INVALIDATE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_THIS_HALF_LEFT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLAY_CODE_OPEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLAY_CODE_GAP = 2'd2;

  localparam logic [REASON_W-1:0] REPLAY_CODE_OPEN_RESET = 8'h02;
  localparam logic [REASON_W-1:0] REPLAY_CODE_GAP_RESET = 8'h05;

  typedef struct packed {
    logic                action;
    logic [REASON_W-1:0] reason;
    logic [BITMAP_W-1:0] pressed_bits;
  } snap_item_t;

  typedef struct packed {
    logic [KEY_ROW_W-1:0] key_row;
    logic [KEY_COL_W-1:0] key_col;
    logic                 key_pressed;
    logic                 last_event;
  } evt_item_t;

  typedef struct packed {
    logic                load;
    logic                left;
    logic [BITMAP_W-1:0] changed;
    logic [BITMAP_W-1:0] pressed;
  } scan_load_t;

endpackage

FILE: rtl/kbce_scan.sv
// Key scanner: shifts event/pressed masks one key per cycle unless stalled.
// Depends on kbce_pkg and key_bitmap_change_events_macros.svh.
`include "key_bitmap_change_events_macros.svh"

module kbce_scan #(
  parameter int ROWS_PER_HALF = 5,
  parameter int COLUMNS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kbce_pkg::scan_load_t  load,
  input  logic                  take,
  output logic                  busy,
  output logic                  emit,
  output kbce_pkg::evt_item_t   evt_next
);

  localparam int MatrixKeys = ROWS_PER_HALF * COLUMNS;
  localparam int ScanKeys = (MatrixKeys < kbce_pkg::BITMAP_W) ? MatrixKeys : kbce_pkg::BITMAP_W;
  localparam int ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RowW = $clog2(2 * ROWS_PER_HALF);

  logic [ScanKeys-1:0] ev;
  logic [ScanKeys-1:0] now;
  logic [ColW-1:0]     col;
  logic [RowW-1:0]     row;
  logic [ScanKeys-1:0] ev_rest;
  logic                advance;

  assign busy = (ev != '0);
  assign ev_rest = ev >> 1;
  assign advance = busy && (!ev[0] || take);
  assign emit = ev[0] && take;

  always_comb begin
    evt_next.key_row = kbce_pkg::KEY_ROW_W'(row);
    evt_next.key_col = kbce_pkg::KEY_COL_W'(col);
    evt_next.key_pressed = now[0];
    evt_next.last_event = (ev_rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else if (load.load) begin
      ev <= load.changed[ScanKeys-1:0];
      now <= load.pressed[ScanKeys-1:0];
      col <= '0;
      row <= load.left ? RowW'(ROWS_PER_HALF) : '0;
    end else if (advance) begin
      ev <= ev_rest;
      now <= now >> 1;
      if (col == ColW'(COLUMNS - 1)) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  `KBCE_ASSERT_NOW(a_load_when_idle, load.load, !busy)
  `KBCE_ASSERT_NEXT(a_last_ends_scan, emit && evt_next.last_event, !busy)
  `KBCE_ASSERT_NEXT(a_more_after_non_last, emit && !evt_next.last_event, busy)

endmodule

FILE: rtl/key_bitmap_change_events.sv
// Top level of the key bitmap change event block: configuration registers,
// stored bitmap, input handshake and output register. Depends on kbce_pkg, kbce_scan.
//
// An apply item is scanned one key per cycle in row-major order by a shift
// sequencer, which holds while the output is stalled and stops as soon as
// no event remains. An invalidate item or a snapshot with no events leaves
// snap_ready high, so the next item can be accepted. snap_ready is low while
// a scan is in progress; the output register lets the next item enter while
// the last event still waits to be taken.
module key_bitmap_change_events #(
  parameter int ROWS_PER_HALF = 5,
  parameter int COLUMNS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  snap_valid,
  output logic                                  snap_ready,
  input  kbce_pkg::snap_item_t                  snap,
  output logic                                  evt_valid,
  input  logic                                  evt_ready,
  output kbce_pkg::evt_item_t                   evt,
  input  logic                                  wr_en,
  input  logic [kbce_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [kbce_pkg::CFG_DATA_W-1:0]       wr_data
);

  logic                              this_half_left;
  logic [kbce_pkg::REASON_W-1:0]     replay_code_open;
  logic [kbce_pkg::REASON_W-1:0]     replay_code_gap;
  logic [kbce_pkg::BITMAP_W-1:0]     prior_bitmap;
  logic                              prior_valid;
  logic [kbce_pkg::BITMAP_W-1:0]     prior_map;
  logic                              replay;
  logic                              accept;
  logic                              busy;
  logic                              emit;
  logic                              take;
  kbce_pkg::scan_load_t              load;
  kbce_pkg::evt_item_t               evt_next;

  assign snap_ready = !busy;
  assign accept = snap_valid && snap_ready;
  assign take = !evt_valid || evt_ready;
  assign prior_map = prior_valid ? prior_bitmap : '0;
  assign replay = (snap.reason == replay_code_open) || (snap.reason == replay_code_gap);

  always_comb begin
    load.load = accept && (snap.action == kbce_pkg::ACTION_APPLY);
    load.left = this_half_left;
    load.pressed = snap.pressed_bits;
    load.changed = (snap.pressed_bits ^ prior_map) | (replay ? snap.pressed_bits : '0);
  end

  kbce_scan #(
    .ROWS_PER_HALF(ROWS_PER_HALF),
    .COLUMNS(COLUMNS)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .load(load),
    .take(take),
    .busy(busy),
    .emit(emit),
    .evt_next(evt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      this_half_left <= 1'b0;
      replay_code_open <= kbce_pkg::REPLAY_CODE_OPEN_RESET;
      replay_code_gap <= kbce_pkg::REPLAY_CODE_GAP_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        kbce_pkg::REG_THIS_HALF_LEFT: this_half_left <= wr_data[0];
        kbce_pkg::REG_REPLAY_CODE_OPEN: replay_code_open <= wr_data;
        kbce_pkg::REG_REPLAY_CODE_GAP: replay_code_gap <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_bitmap <= '0;
      prior_valid <= 1'b0;
    end else if (accept) begin
      if (snap.action == kbce_pkg::ACTION_INVALIDATE) begin
        prior_valid <= 1'b0;
      end else begin
        prior_bitmap <= snap.pressed_bits;
        prior_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (emit) begin
      evt_valid <= 1'b1;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt <= evt_next;
    end
  end

endmodule
